>>> design/rssp_pkg.sv
// Shared types, codes and helpers for the ramp/soak setpoint programmer.
// No dependencies; imported by every module of the block.
package rssp_pkg;

  // Temperature limits for further step targets (tenths of degree)
  localparam logic signed [15:0] TEMP_MIN = 16'sd0;
  localparam logic signed [15:0] TEMP_MAX = 16'sd1100;

  // Fixed tick length of the one-second program tick
  localparam logic [15:0] PROG_TICK_MS = 16'd1000;

  // Division by 60000 as a reciprocal multiply: q = (p * RECIP) >> RECIP_SHIFT.
  // Exact for every product below 2^31.
  localparam logic [31:0] RECIP_60000 = 32'd2345624806;
  localparam int unsigned RECIP_SHIFT = 47;

  // Command codes
  typedef enum logic [2:0] {
    CMD_STOP  = 3'd0,
    CMD_HOLD  = 3'd1,
    CMD_PROG  = 3'd2,
    CMD_HTICK = 3'd3,
    CMD_STICK = 3'd4,
    CMD_FAULT = 3'd5
  } cmd_e;

  // Run modes
  typedef enum logic [1:0] {
    MODE_STOP = 2'd0,
    MODE_HOLD = 2'd1,
    MODE_PROG = 2'd2
  } mode_e;

  // Program stages
  typedef enum logic [2:0] {
    STG_IDLE     = 3'd0,
    STG_APPROACH = 3'd1,
    STG_SOAK     = 3'd2,
    STG_RAMP     = 3'd3,
    STG_WAIT     = 3'd4,
    STG_DONE     = 3'd5
  } stage_e;

  // Configuration register indexes
  localparam logic [2:0] CFG_HOLD_TARGET     = 3'd0;
  localparam logic [2:0] CFG_HOLD_RAMP_RATE  = 3'd1;
  localparam logic [2:0] CFG_PROG_START_TEMP = 3'd2;
  localparam logic [2:0] CFG_PROG_START_HOLD = 3'd3;
  localparam logic [2:0] CFG_PROG_RAMP_RATE  = 3'd4;
  localparam logic [2:0] CFG_PROG_NEXT_TEMP  = 3'd5;
  localparam logic [2:0] CFG_PROG_WAIT       = 3'd6;
  localparam logic [2:0] CFG_PROG_REPEATS    = 3'd7;

  localparam logic signed [15:0] HOLD_RAMP_RATE_RST = 16'sd50;

  // Configuration register file
  typedef struct packed {
    logic signed [15:0] hold_target;
    logic signed [15:0] hold_ramp_rate;
    logic signed [15:0] prog_start_temp;
    logic [15:0]        prog_start_hold;
    logic signed [15:0] prog_ramp_rate;
    logic signed [15:0] prog_next_temp;
    logic [15:0]        prog_wait;
    logic [15:0]        prog_repeats;
  } cfg_t;

  // Input beat
  typedef struct packed {
    logic [2:0]         command;
    logic signed [15:0] measured_temp;
    logic [15:0]        elapsed_ms;
    logic [7:0]         fault_code;
  } in_t;

  // Result beat
  typedef struct packed {
    logic signed [15:0] setpoint;
    logic               drive_enable;
    logic [1:0]         run_state;
    logic [2:0]         program_stage;
    logic               start_pulse;
    logic               stop_pulse;
    logic               refused;
    logic [7:0]         fault;
  } out_t;

  // Item with its precomputed ramp steps, handed to the state update
  typedef struct packed {
    in_t         item;
    logic [15:0] step_hold;  // hold rate step, already at least 1
    logic        jump_hold;  // hold rate is zero
    logic [15:0] step_prog;  // program rate step for one second
    logic        jump_prog;  // program rate is zero
  } step_item_t;

  // One rate-limited move of cur toward tgt
  function automatic logic signed [15:0] ramp_step(input logic signed [15:0] cur,
                                                   input logic signed [15:0] tgt,
                                                   input logic [15:0]        step,
                                                   input logic               jump);
    logic signed [16:0] diff;
    logic [16:0]        mag;
    logic signed [15:0] res;
    diff = $signed({tgt[15], tgt}) - $signed({cur[15], cur});
    mag  = diff[16] ? 17'($unsigned(-diff)) : 17'($unsigned(diff));
    if (jump || (diff == 17'sd0) || (mag <= {1'b0, step})) begin
      res = tgt;
    end else if (!diff[16]) begin
      res = $signed(16'($unsigned(cur) + step));
    end else begin
      res = $signed(16'($unsigned(cur) - step));
    end
    return res;
  endfunction

  // Magnitude of a 16-bit signed rate; -32768 gives 32768
  function automatic logic [15:0] rate_abs(input logic signed [15:0] rate);
    logic [15:0] res;
    res = rate[15] ? 16'(~$unsigned(rate) + 16'd1) : $unsigned(rate);
    return res;
  endfunction

endpackage

>>> design/rssp_step_calc.sv
// Two-stage ramp step pipeline: rate times milliseconds, then divide by 60000.
// Depends on rssp_pkg.
module rssp_step_calc (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rssp_pkg::cfg_t         cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  rssp_pkg::in_t          in_data_i,
  output logic                   step_valid_o,
  input  logic                   step_take_i,
  output rssp_pkg::step_item_t   step_data_o
);
  import rssp_pkg::*;

  // Stage 1: products
  logic        v1_q;
  in_t         item1_q;
  logic [31:0] prod_hold_q;
  logic [31:0] prod_prog_q;
  logic        jump_hold1_q, jump_prog1_q;

  // Stage 2: quotients
  logic        v2_q;
  step_item_t  s2_q;

  logic        adv1, adv2;
  logic [15:0] r_hold, r_prog, ms_hold;
  logic [63:0] quot_hold_full, quot_prog_full;
  logic [15:0] q_hold, q_prog;

  assign adv2       = !v2_q || step_take_i;
  assign adv1       = !v1_q || adv2;
  assign in_stall_o = !adv1;

  // Rate magnitudes and tick length
  assign r_hold  = rate_abs(cfg_i.hold_ramp_rate);
  assign r_prog  = rate_abs(cfg_i.prog_ramp_rate);
  assign ms_hold = (in_data_i.command == CMD_STICK) ? PROG_TICK_MS : in_data_i.elapsed_ms;

  // Reciprocal multiply for the divide by 60000
  assign quot_hold_full = {32'd0, prod_hold_q} * {32'd0, RECIP_60000};
  assign quot_prog_full = {32'd0, prod_prog_q} * {32'd0, RECIP_60000};
  assign q_hold = quot_hold_full[RECIP_SHIFT+15:RECIP_SHIFT];
  assign q_prog = quot_prog_full[RECIP_SHIFT+15:RECIP_SHIFT];

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= in_valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      item1_q      <= in_data_i;
      prod_hold_q  <= {16'd0, r_hold} * {16'd0, ms_hold};
      prod_prog_q  <= {16'd0, r_prog} * {16'd0, PROG_TICK_MS};
      jump_hold1_q <= (r_hold == 16'd0);
      jump_prog1_q <= (r_prog == 16'd0);
    end
    if (adv2 && v1_q) begin
      s2_q.item      <= item1_q;
      s2_q.step_hold <= (q_hold == 16'd0) ? 16'd1 : q_hold;
      s2_q.jump_hold <= jump_hold1_q;
      s2_q.step_prog <= (q_prog == 16'd0) ? 16'd1 : q_prog;
      s2_q.jump_prog <= jump_prog1_q;
    end
  end

  assign step_valid_o = v2_q;
  assign step_data_o  = s2_q;

endmodule

>>> design/rssp_ctrl.sv
// Mode and program sequencer: state update and result register.
// Depends on rssp_pkg.
module rssp_ctrl #(
  parameter logic signed [15:0] TempMin = rssp_pkg::TEMP_MIN,
  parameter logic signed [15:0] TempMax = rssp_pkg::TEMP_MAX
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rssp_pkg::cfg_t       cfg_i,
  input  logic                 step_valid_i,
  output logic                 step_take_o,
  input  rssp_pkg::step_item_t step_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rssp_pkg::out_t       out_data_o
);
  import rssp_pkg::*;

  mode_e              mode_q, mode_d;
  stage_e             stage_q, stage_d;
  logic signed [15:0] temp_q, temp_d;
  logic [15:0]        timer_q, timer_d;
  logic [15:0]        steps_q, steps_d;
  logic signed [15:0] target_q, target_d;
  logic signed [16:0] size_q, size_d;
  logic [7:0]         fault_q, fault_d;
  logic               out_valid_q;
  out_t               out_q;

  logic               sp, tp, rf, fire;
  in_t                it;
  logic signed [15:0] ramp_hold, ramp_start, ramp_prog, clamped;
  logic signed [17:0] next_sum;

  assign it          = step_data_i.item;
  assign step_take_o = !out_valid_q || !out_stall_i;
  assign fire        = step_valid_i && step_take_o;

  // Candidate ramp moves
  assign ramp_hold  = ramp_step(temp_q, cfg_i.hold_target, step_data_i.step_hold,
                                step_data_i.jump_hold);
  assign ramp_start = ramp_step(temp_q, cfg_i.prog_start_temp, step_data_i.step_hold,
                                step_data_i.jump_hold);
  assign ramp_prog  = ramp_step(temp_q, target_q, step_data_i.step_prog,
                                step_data_i.jump_prog);

  // Next step target, saturated to the limits
  assign next_sum = $signed({{2{target_q[15]}}, target_q}) + $signed({size_q[16], size_q});
  always_comb begin
    if (next_sum < $signed({{2{TempMin[15]}}, TempMin})) begin
      clamped = TempMin;
    end else if (next_sum > $signed({{2{TempMax[15]}}, TempMax})) begin
      clamped = TempMax;
    end else begin
      clamped = next_sum[15:0];
    end
  end

  // Command decode and program sequencing
  always_comb begin
    mode_d   = mode_q;
    stage_d  = stage_q;
    temp_d   = temp_q;
    timer_d  = timer_q;
    steps_d  = steps_q;
    target_d = target_q;
    size_d   = size_q;
    fault_d  = fault_q;
    sp       = 1'b0;
    tp       = 1'b0;
    rf       = 1'b0;
    case (it.command)
      CMD_STOP: begin
        mode_d  = MODE_STOP;
        stage_d = STG_IDLE;
        timer_d = 16'd0;
        steps_d = 16'd0;
        tp      = 1'b1;
      end
      CMD_HOLD: begin
        if (fault_q != 8'd0) begin
          rf = 1'b1;
        end else begin
          mode_d = MODE_HOLD;
          temp_d = it.measured_temp;
          sp     = 1'b1;
        end
      end
      CMD_PROG: begin
        if (fault_q != 8'd0) begin
          rf = 1'b1;
        end else begin
          mode_d   = MODE_PROG;
          stage_d  = STG_APPROACH;
          timer_d  = 16'd0;
          steps_d  = 16'd0;
          size_d   = $signed({cfg_i.prog_next_temp[15], cfg_i.prog_next_temp})
                   - $signed({cfg_i.prog_start_temp[15], cfg_i.prog_start_temp});
          target_d = cfg_i.prog_start_temp;
          temp_d   = it.measured_temp;
          sp       = 1'b1;
        end
      end
      CMD_HTICK: begin
        if (mode_q == MODE_HOLD) begin
          temp_d = ramp_hold;
        end
      end
      CMD_STICK: begin
        if (mode_q == MODE_PROG) begin
          case (stage_q)
            STG_APPROACH: begin
              temp_d = ramp_start;
              if (ramp_start == cfg_i.prog_start_temp) begin
                stage_d = STG_SOAK;
                timer_d = 16'd0;
              end
            end
            STG_SOAK: begin
              temp_d = cfg_i.prog_start_temp;
              if (timer_q >= cfg_i.prog_start_hold) begin
                stage_d  = STG_RAMP;
                timer_d  = 16'd0;
                target_d = cfg_i.prog_next_temp;
              end else begin
                timer_d = timer_q + 16'd1;
              end
            end
            STG_RAMP: begin
              temp_d = ramp_prog;
              if (ramp_prog == target_q) begin
                stage_d = STG_WAIT;
                timer_d = 16'd0;
              end
            end
            STG_WAIT: begin
              temp_d = target_q;
              if (timer_q >= cfg_i.prog_wait) begin
                timer_d = 16'd0;
                if (steps_q >= cfg_i.prog_repeats) begin
                  stage_d = STG_DONE;
                end else begin
                  steps_d  = steps_q + 16'd1;
                  target_d = clamped;
                  stage_d  = STG_RAMP;
                end
              end else begin
                timer_d = timer_q + 16'd1;
              end
            end
            STG_DONE: begin
              temp_d = target_q;
            end
            default: begin
              // idle or unknown stage: restart at approach
              stage_d = STG_APPROACH;
            end
          endcase
        end
      end
      CMD_FAULT: begin
        fault_d = it.fault_code;
        if (it.fault_code != 8'd0) begin
          mode_d  = MODE_STOP;
          stage_d = STG_IDLE;
          timer_d = 16'd0;
          steps_d = 16'd0;
          tp      = 1'b1;
        end
      end
      default: begin
        // unused command codes leave everything alone
      end
    endcase
  end

  // State and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_STOP;
      stage_q     <= STG_IDLE;
      temp_q      <= 16'sd0;
      timer_q     <= 16'd0;
      steps_q     <= 16'd0;
      target_q    <= 16'sd0;
      size_q      <= 17'sd0;
      fault_q     <= 8'd0;
      out_valid_q <= 1'b0;
    end else if (step_take_o) begin
      out_valid_q <= step_valid_i;
      if (fire) begin
        mode_q   <= mode_d;
        stage_q  <= stage_d;
        temp_q   <= temp_d;
        timer_q  <= timer_d;
        steps_q  <= steps_d;
        target_q <= target_d;
        size_q   <= size_d;
        fault_q  <= fault_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.setpoint      <= temp_d;
      out_q.drive_enable  <= (mode_d != MODE_STOP);
      out_q.run_state     <= mode_d;
      out_q.program_stage <= stage_d;
      out_q.start_pulse   <= sp;
      out_q.stop_pulse    <= tp;
      out_q.refused       <= rf;
      out_q.fault         <= fault_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> design/ramp_soak_setpoint_programmer.sv
// Ramp/soak setpoint programmer top level: configuration registers and pipeline.
// Depends on rssp_pkg, rssp_step_calc and rssp_ctrl.
//
// One command beat in gives one result beat out. A new beat is taken every
// clock while the output is not stalled; each beat passes the two step
// stages, rate times milliseconds and the divide by 60000 as a reciprocal
// multiply, then the mode/stage update that loads the result register. The
// throughput of one beat per clock is set by that last state register. While
// the result register is stalled, the two step stages still fill before the
// input stalls. Configuration writes are always ready and must be made only
// while no beat is in flight. There is no clearing pass after reset.
module ramp_soak_setpoint_programmer #(
  parameter logic signed [15:0] TempMin = rssp_pkg::TEMP_MIN,
  parameter logic signed [15:0] TempMax = rssp_pkg::TEMP_MAX
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [2:0]     cfg_index_i,
  input  logic [15:0]    cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rssp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rssp_pkg::out_t out_data_o
);
  import rssp_pkg::*;

  cfg_t       cfg_q;
  logic       step_valid, step_take;
  step_item_t step_data;

  assign cfg_ready_o = 1'b1;

  // Configuration register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{hold_target:     16'sd0,
                 hold_ramp_rate:  HOLD_RAMP_RATE_RST,
                 prog_start_temp: 16'sd0,
                 prog_start_hold: 16'd0,
                 prog_ramp_rate:  16'sd0,
                 prog_next_temp:  16'sd0,
                 prog_wait:       16'd0,
                 prog_repeats:    16'd0};
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_HOLD_TARGET:     cfg_q.hold_target     <= $signed(cfg_data_i);
        CFG_HOLD_RAMP_RATE:  cfg_q.hold_ramp_rate  <= $signed(cfg_data_i);
        CFG_PROG_START_TEMP: cfg_q.prog_start_temp <= $signed(cfg_data_i);
        CFG_PROG_START_HOLD: cfg_q.prog_start_hold <= cfg_data_i;
        CFG_PROG_RAMP_RATE:  cfg_q.prog_ramp_rate  <= $signed(cfg_data_i);
        CFG_PROG_NEXT_TEMP:  cfg_q.prog_next_temp  <= $signed(cfg_data_i);
        CFG_PROG_WAIT:       cfg_q.prog_wait       <= cfg_data_i;
        CFG_PROG_REPEATS:    cfg_q.prog_repeats    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Ramp step pipeline
  rssp_step_calc u_step_calc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .step_valid_o (step_valid),
    .step_take_i  (step_take),
    .step_data_o  (step_data)
  );

  // Sequencer and result register
  rssp_ctrl #(
    .TempMin (TempMin),
    .TempMax (TempMax)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .step_valid_i (step_valid),
    .step_take_o  (step_take),
    .step_data_i  (step_data),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

>>> verif/tb.sv
// Self-checking testbench for ramp_soak_setpoint_programmer: directed table, then random phases.
// Depends on rssp_pkg and the block's RTL; results are checked against an in-bench predictor.
module tb;
  import rssp_pkg::*;

  // Commands the block ignores
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam int         N_ROWS     = 27;
  localparam int         N_PHASES   = 12;
  localparam int         PHASE_BEATS = 140;

  typedef struct packed {
    in_t  item;
    logic typed;
    out_t res;
  } row_t;

  localparam out_t NO_RES = '0;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  out_t        out_data_o;

  // Expected result beats, oldest first
  out_t        setpoint_q [$];
  int          mismatch_count = 0;
  logic        quiet = 1'b0;
  row_t        dir_rows [N_ROWS];
  out_t        want;

  // Predictor state: register copy plus run state
  logic [15:0] reg_mirror [8];
  mode_e       pred_mode = MODE_STOP;
  logic [2:0]  pred_stage = STG_IDLE;
  int          pred_temp = 0;
  int unsigned pred_timer = 0;
  int unsigned pred_steps = 0;
  int          pred_target = 0;
  int          pred_delta = 0;
  logic [7:0]  pred_fault = '0;

  ramp_soak_setpoint_programmer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  // Signed view of a register copy
  function automatic int sreg(input logic [2:0] idx);
    return int'($signed(reg_mirror[idx]));
  endfunction

  // Rate-limited move toward tgt; rate in tenths per minute, sign ignored
  function automatic int ramp_toward(input int cur, input int tgt, input int rate,
                                     input int unsigned ms);
    longint unsigned mag, stride;
    int diff;
    mag  = (rate < 0) ? longint'(-rate) : longint'(rate);
    diff = tgt - cur;
    if (mag == 0 || diff == 0) return tgt;
    stride = (mag * ms) / 60000;
    if (stride < 1) stride = 1;
    if (diff > 0) return (longint'(diff) <= longint'(stride)) ? tgt : cur + int'(stride);
    return (longint'(-diff) <= longint'(stride)) ? tgt : cur - int'(stride);
  endfunction

  function automatic void halt_run();
    pred_mode  = MODE_STOP;
    pred_stage = STG_IDLE;
    pred_timer = 0;
    pred_steps = 0;
  endfunction

  // Advance the predicted state by one command beat and form its result
  task automatic predict_setpoint(input in_t it, output out_t res);
    int   start, next_tgt;
    logic started, stopped, refusal;
    started = 1'b0;
    stopped = 1'b0;
    refusal = 1'b0;
    start   = sreg(CFG_PROG_START_TEMP);
    case (it.command)
      CMD_STOP: begin
        halt_run();
        stopped = 1'b1;
      end
      CMD_HOLD: begin
        if (pred_fault != 8'd0) begin
          refusal = 1'b1;
        end else begin
          pred_mode = MODE_HOLD;
          pred_temp = int'($signed(it.measured_temp));
          started   = 1'b1;
        end
      end
      CMD_PROG: begin
        if (pred_fault != 8'd0) begin
          refusal = 1'b1;
        end else begin
          pred_mode   = MODE_PROG;
          pred_stage  = STG_APPROACH;
          pred_timer  = 0;
          pred_steps  = 0;
          pred_delta  = sreg(CFG_PROG_NEXT_TEMP) - start;
          pred_target = start;
          pred_temp   = int'($signed(it.measured_temp));
          started     = 1'b1;
        end
      end
      CMD_HTICK: begin
        if (pred_mode == MODE_HOLD) begin
          pred_temp = ramp_toward(pred_temp, sreg(CFG_HOLD_TARGET), sreg(CFG_HOLD_RAMP_RATE),
                                  it.elapsed_ms);
        end
      end
      CMD_STICK: begin
        // one second of the program sequence
        if (pred_mode == MODE_PROG) begin
          case (pred_stage)
            STG_APPROACH: begin
              pred_temp = ramp_toward(pred_temp, start, sreg(CFG_HOLD_RAMP_RATE), PROG_TICK_MS);
              if (pred_temp == start) begin
                pred_stage = STG_SOAK;
                pred_timer = 0;
              end
            end
            STG_SOAK: begin
              pred_temp = start;
              if (pred_timer >= reg_mirror[CFG_PROG_START_HOLD]) begin
                pred_stage  = STG_RAMP;
                pred_timer  = 0;
                pred_target = sreg(CFG_PROG_NEXT_TEMP);
              end else begin
                pred_timer++;
              end
            end
            STG_RAMP: begin
              pred_temp = ramp_toward(pred_temp, pred_target, sreg(CFG_PROG_RAMP_RATE),
                                      PROG_TICK_MS);
              if (pred_temp == pred_target) begin
                pred_stage = STG_WAIT;
                pred_timer = 0;
              end
            end
            STG_WAIT: begin
              pred_temp = pred_target;
              if (pred_timer >= reg_mirror[CFG_PROG_WAIT]) begin
                pred_timer = 0;
                if (pred_steps >= reg_mirror[CFG_PROG_REPEATS]) begin
                  pred_stage = STG_DONE;
                end else begin
                  // further targets saturate to the temperature limits
                  pred_steps++;
                  next_tgt = pred_target + pred_delta;
                  if (next_tgt < int'(TEMP_MIN)) next_tgt = int'(TEMP_MIN);
                  if (next_tgt > int'(TEMP_MAX)) next_tgt = int'(TEMP_MAX);
                  pred_target = next_tgt;
                  pred_stage  = STG_RAMP;
                end
              end else begin
                pred_timer++;
              end
            end
            STG_DONE: begin
              pred_temp = pred_target;
            end
            default: begin
              pred_stage = STG_APPROACH;
            end
          endcase
        end
      end
      CMD_FAULT: begin
        pred_fault = it.fault_code;
        if (it.fault_code != 8'd0) begin
          halt_run();
          stopped = 1'b1;
        end
      end
      default: ;
    endcase
    res.setpoint      = 16'(pred_temp);
    res.drive_enable  = (pred_mode != MODE_STOP);
    res.run_state     = pred_mode;
    res.program_stage = pred_stage;
    res.start_pulse   = started;
    res.stop_pulse    = stopped;
    res.refused       = refusal;
    res.fault         = pred_fault;
  endtask

  // Register write; cfg_valid_i stays high for a following write
  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    reg_mirror[idx] = val;
    @(negedge clk_i);
  endtask

  // Send one command beat; a typed expectation replaces the predicted one
  task automatic push_item(input in_t it, input logic typed, input out_t typed_res);
    int   gap;
    out_t res;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_setpoint(it, res);
    setpoint_q.push_back(typed ? typed_res : res);
    @(negedge clk_i);
  endtask

  task automatic send_cmd(input logic [2:0] cmd, input logic [15:0] meas,
                          input logic [15:0] ms, input logic [7:0] code);
    in_t it;
    it.command       = cmd;
    it.measured_temp = meas;
    it.elapsed_ms    = ms;
    it.fault_code    = code;
    push_item(it, 1'b0, NO_RES);
  endtask

  task automatic send_noise();
    send_cmd(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  function automatic logic [15:0] temp_around(input int center, input int spread);
    return 16'(center + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // Mostly moderate rates with random sign, some zero, some anything
  function automatic logic [15:0] pick_rate();
    int mag;
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'($urandom);
      default: begin
        mag = $urandom_range(300, 6000);
        return $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
      end
    endcase
  endfunction

  // Wait for every expected beat, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (setpoint_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Write all registers: the first phases use extremes, the rest random profiles
  task automatic load_profile(input int phase);
    logic [15:0] v [8];
    case (phase)
      0: begin
        v[CFG_HOLD_TARGET]     = 16'h7FFF;
        v[CFG_HOLD_RAMP_RATE]  = 16'h8000;
        v[CFG_PROG_START_TEMP] = 16'h8000;
        v[CFG_PROG_START_HOLD] = 16'hFFFF;
        v[CFG_PROG_RAMP_RATE]  = 16'h8000;
        v[CFG_PROG_NEXT_TEMP]  = 16'h7FFF;
        v[CFG_PROG_WAIT]       = 16'hFFFF;
        v[CFG_PROG_REPEATS]    = 16'hFFFF;
      end
      1: begin
        v[CFG_HOLD_TARGET]     = 16'h8000;
        v[CFG_HOLD_RAMP_RATE]  = 16'h0000;
        v[CFG_PROG_START_TEMP] = 16'h7FFF;
        v[CFG_PROG_START_HOLD] = 16'h0000;
        v[CFG_PROG_RAMP_RATE]  = 16'h7FFF;
        v[CFG_PROG_NEXT_TEMP]  = 16'h8000;
        v[CFG_PROG_WAIT]       = 16'h0000;
        v[CFG_PROG_REPEATS]    = 16'hFFFF;
      end
      2: begin
        // slowest nonzero rates, downward steps that hit the lower limit
        v[CFG_HOLD_TARGET]     = 16'd20;
        v[CFG_HOLD_RAMP_RATE]  = 16'hFFFF;
        v[CFG_PROG_START_TEMP] = 16'd3;
        v[CFG_PROG_START_HOLD] = 16'd1;
        v[CFG_PROG_RAMP_RATE]  = 16'd1;
        v[CFG_PROG_NEXT_TEMP]  = 16'hFFFE;
        v[CFG_PROG_WAIT]       = 16'd2;
        v[CFG_PROG_REPEATS]    = 16'd3;
      end
      default: begin
        v[CFG_HOLD_TARGET]     = temp_around(550, 850);
        v[CFG_HOLD_RAMP_RATE]  = pick_rate();
        v[CFG_PROG_START_TEMP] = temp_around(550, 650);
        v[CFG_PROG_START_HOLD] = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 30))
                                                             : 16'($urandom_range(0, 4));
        v[CFG_PROG_RAMP_RATE]  = pick_rate();
        v[CFG_PROG_NEXT_TEMP]  = temp_around(600, 800);
        v[CFG_PROG_WAIT]       = 16'($urandom_range(0, 4));
        v[CFG_PROG_REPEATS]    = 16'($urandom_range(0, 6));
      end
    endcase
    for (int i = 0; i < 8; i++) cfg_write(3'(i), v[i]);
    cfg_valid_i <= 1'b0;
  endtask

  // Random traffic: mostly program and hold runs, plus faults and noise
  task automatic run_phase(input int budget);
    int sent, k, pick;
    sent = 0;
    while (sent < budget) begin
      quiet = ($urandom_range(0, 4) == 0);
      pick  = $urandom_range(0, 99);
      if (pick < 45) begin
        send_cmd(CMD_PROG, ($urandom_range(0, 9) < 7) ?
                 temp_around(sreg(CFG_PROG_START_TEMP), 300) : 16'($urandom),
                 16'($urandom), 8'($urandom));
        k = $urandom_range(10, 80);
        repeat (k) begin
          if ($urandom_range(0, 19) == 0) begin
            send_noise();
          end else begin
            send_cmd(CMD_STICK, 16'($urandom), 16'($urandom), 8'($urandom));
          end
        end
        sent += k + 1;
      end else if (pick < 75) begin
        send_cmd(CMD_HOLD, ($urandom_range(0, 9) < 7) ?
                 temp_around(sreg(CFG_HOLD_TARGET), 400) : 16'($urandom),
                 16'($urandom), 8'($urandom));
        k = $urandom_range(3, 25);
        repeat (k) begin
          send_cmd(CMD_HTICK, 16'($urandom), $urandom_range(0, 1) ?
                   16'($urandom_range(0, 2000)) : 16'($urandom), 8'($urandom));
        end
        sent += k + 1;
      end else if (pick < 85) begin
        // fault, a start that may be refused, then usually a clear
        send_cmd(CMD_FAULT, 16'($urandom), 16'($urandom),
                 ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
        if ($urandom_range(0, 1)) begin
          send_cmd($urandom_range(0, 1) ? CMD_HOLD : CMD_PROG, 16'($urandom),
                   16'($urandom), 8'($urandom));
        end
        if ($urandom_range(0, 9) < 7) begin
          send_cmd(CMD_FAULT, 16'($urandom), 16'($urandom), 8'd0);
        end
        sent += 3;
      end else begin
        send_noise();
        sent += 1;
      end
    end
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // Result side: compare every accepted beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (setpoint_q.size() == 0) begin
        $error("result beat with nothing expected: setpoint %0d", out_data_o.setpoint);
        mismatch_count++;
      end else begin
        want = setpoint_q.pop_front();
        check_field("setpoint", int'(want.setpoint), int'(out_data_o.setpoint));
        check_field("drive_enable", want.drive_enable, out_data_o.drive_enable);
        check_field("run_state", want.run_state, out_data_o.run_state);
        check_field("program_stage", want.program_stage, out_data_o.program_stage);
        check_field("start_pulse", want.start_pulse, out_data_o.start_pulse);
        check_field("stop_pulse", want.stop_pulse, out_data_o.stop_pulse);
        check_field("refused", want.refused, out_data_o.refused);
        check_field("fault", want.fault, out_data_o.fault);
      end
    end
  end

  // Result side stall: random hold-off per beat, none while quiet
  initial begin : result_stall
    int hold_off;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      hold_off = quiet ? 0 : $urandom_range(0, 3);
      if (hold_off != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_off) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  initial begin : run_limit
    #2000000;
    $display("tb: errors");
    $finish;
  end

  initial begin : stimulus
    foreach (reg_mirror[i]) reg_mirror[i] = '0;
    reg_mirror[CFG_HOLD_RAMP_RATE] = HOLD_RAMP_RATE_RST;

    // Directed table at reset register values; typed rows follow from the command rules
    dir_rows = '{
      '{'{CMD_STOP, 16'sd0, 16'd0, 8'd0}, 1'b1,
        '{16'sd0, 1'b0, MODE_STOP, STG_IDLE, 1'b0, 1'b1, 1'b0, 8'd0}},
      '{'{CMD_HTICK, 16'sd0, 16'd60000, 8'd0}, 1'b1, NO_RES},
      '{'{CMD_STICK, 16'sd0, 16'd0, 8'd0}, 1'b1, NO_RES},
      '{'{CMD_SPARE6, 16'sh8000, 16'hFFFF, 8'hFF}, 1'b1, NO_RES},
      '{'{CMD_SPARE7, 16'sh7FFF, 16'hFFFF, 8'h01}, 1'b1, NO_RES},
      '{'{CMD_HOLD, 16'sh7FFF, 16'd0, 8'd0}, 1'b1,
        '{16'sh7FFF, 1'b1, MODE_HOLD, STG_IDLE, 1'b1, 1'b0, 1'b0, 8'd0}},
      '{'{CMD_HTICK, 16'sd0, 16'hFFFF, 8'd0}, 1'b0, NO_RES},
      '{'{CMD_HTICK, 16'sd0, 16'd0, 8'd0}, 1'b0, NO_RES},
      '{'{CMD_STICK, 16'sd0, 16'd0, 8'd0}, 1'b0, NO_RES},
      '{'{CMD_HOLD, 16'sh8000, 16'd0, 8'd0}, 1'b1,
        '{16'sh8000, 1'b1, MODE_HOLD, STG_IDLE, 1'b1, 1'b0, 1'b0, 8'd0}},
      '{'{CMD_FAULT, 16'sd0, 16'd0, 8'hFF}, 1'b1,
        '{16'sh8000, 1'b0, MODE_STOP, STG_IDLE, 1'b0, 1'b1, 1'b0, 8'hFF}},
      '{'{CMD_HOLD, 16'sd5, 16'd0, 8'd0}, 1'b1,
        '{16'sh8000, 1'b0, MODE_STOP, STG_IDLE, 1'b0, 1'b0, 1'b1, 8'hFF}},
      '{'{CMD_PROG, 16'sd5, 16'd0, 8'd0}, 1'b1,
        '{16'sh8000, 1'b0, MODE_STOP, STG_IDLE, 1'b0, 1'b0, 1'b1, 8'hFF}},
      '{'{CMD_FAULT, 16'sd0, 16'd0, 8'd0}, 1'b1,
        '{16'sh8000, 1'b0, MODE_STOP, STG_IDLE, 1'b0, 1'b0, 1'b0, 8'd0}},
      '{'{CMD_PROG, 16'sd100, 16'd0, 8'd0}, 1'b1,
        '{16'sd100, 1'b1, MODE_PROG, STG_APPROACH, 1'b1, 1'b0, 1'b0, 8'd0}},
      '{'{CMD_STICK, 16'sd0, 16'd0, 8'd0}, 1'b0, NO_RES},
      '{'{CMD_HTICK, 16'sd0, 16'd1000, 8'd0}, 1'b0, NO_RES},
      '{'{CMD_HOLD, 16'sd7, 16'd0, 8'd0}, 1'b0, NO_RES},
      '{'{CMD_PROG, 16'sd0, 16'd0, 8'd0}, 1'b0, NO_RES},
      '{'{CMD_STICK, 16'sd0, 16'd0, 8'd0}, 1'b0, NO_RES},
      '{'{CMD_STICK, 16'sd0, 16'd0, 8'd0}, 1'b0, NO_RES},
      '{'{CMD_STICK, 16'sd0, 16'd0, 8'd0}, 1'b0, NO_RES},
      '{'{CMD_STICK, 16'sd0, 16'd0, 8'd0}, 1'b0, NO_RES},
      '{'{CMD_STICK, 16'sd0, 16'd0, 8'd0}, 1'b0, NO_RES},
      '{'{CMD_FAULT, 16'sd0, 16'd0, 8'd1}, 1'b0, NO_RES},
      '{'{CMD_FAULT, 16'sd0, 16'd0, 8'd0}, 1'b0, NO_RES},
      '{'{CMD_STOP, 16'sd0, 16'd0, 8'd0}, 1'b0, NO_RES}
    };

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < N_ROWS; i++) begin
      push_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
    end

    // Random phases, each under a fresh register profile
    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      load_profile(p);
      run_phase(PHASE_BEATS);
    end
    settle();

    if (mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
